// ----- hw/rtl/bpms_pkg.sv -----
// shared types, constants and register indexes of the brake pressure mode selector
package bpms_pkg;

    // width of every pressure, target and pressure-domain threshold
    localparam int PRESSURE_BITS = 12;
    localparam int DRIVE_BITS    = 8;
    localparam int MODE_BITS     = 3;
    localparam int WHEELS        = 4;
    localparam int IN_FIELDS     = 2 * WHEELS;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_BITS  = ((IN_FIELDS * PRESSURE_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = 2 * MODE_BITS + 3 * DRIVE_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (PRESSURE_BITS > DRIVE_BITS) ? PRESSURE_BITS : DRIVE_BITS;

    // fixed rule thresholds
    localparam int KEEP_FLOOR   = 600;
    localparam int RELEASE_CEIL = 500;
    localparam int RELEASE_BAND = 200;

    // axle mode codes
    localparam logic [MODE_BITS-1:0] MODE_RELEASE    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_QUICK_RISE = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SLOW_RISE  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_QUICK_FALL = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_KEEP       = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUICK_RISE_DRIVE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_RISE_DRIVE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_DRIVE         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUICK_RISE_GAP     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_RISE_GAP      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUICK_FALL_GAP     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_BAND          = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERPRESSURE_LIMIT = 3'd7;

    typedef logic [PRESSURE_BITS-1:0] pressure_t;
    typedef logic [DRIVE_BITS-1:0]    drive_t;
    typedef logic [MODE_BITS-1:0]     mode_t;

    // configuration set seen by the lanes and the merge stage
    typedef struct packed {
        drive_t    quick_rise_drive;
        drive_t    slow_rise_drive;
        drive_t    keep_drive;
        pressure_t quick_rise_gap;
        pressure_t slow_rise_gap;
        pressure_t quick_fall_gap;
        pressure_t keep_band;
        pressure_t overpressure_limit;
    } cfg_t;

    // what one axle lane decided
    typedef struct packed {
        mode_t  mode;
        drive_t drive;
    } axle_t;

    // one result transaction
    typedef struct packed {
        logic   overpressure_release;
        drive_t pump_drive;
        drive_t rear_drive;
        drive_t front_drive;
        mode_t  rear_mode;
        mode_t  front_mode;
    } result_t;

endpackage

// ----- hw/rtl/bpms_axle.sv -----
// one axle lane: ordered mode rules and the held mode and drive of that axle
module bpms_axle (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  bpms_pkg::cfg_t      cfg,
    input  bpms_pkg::pressure_t p0,
    input  bpms_pkg::pressure_t t0,
    input  bpms_pkg::pressure_t p1,
    input  bpms_pkg::pressure_t t1,
    output bpms_pkg::axle_t     axle_next
);
    import bpms_pkg::*;

    typedef logic signed [PRESSURE_BITS:0] diff_t;

    axle_t held_reg;

    diff_t up0, up1, dn0, dn1;
    diff_t qr, sr, qf, kb;
    logic signed [31:0] dn0_w, dn1_w;
    logic [31:0] p0_w, p1_w;
    logic fire_qr, fire_sr, fire_qf, fire_keep, fire_rel;

    // signed differences and thresholds
    always_comb begin
        up0   = $signed({1'b0, t0}) - $signed({1'b0, p0});
        up1   = $signed({1'b0, t1}) - $signed({1'b0, p1});
        dn0   = $signed({1'b0, p0}) - $signed({1'b0, t0});
        dn1   = $signed({1'b0, p1}) - $signed({1'b0, t1});
        qr    = $signed({1'b0, cfg.quick_rise_gap});
        sr    = $signed({1'b0, cfg.slow_rise_gap});
        qf    = $signed({1'b0, cfg.quick_fall_gap});
        kb    = $signed({1'b0, cfg.keep_band});
        dn0_w = 32'(dn0);
        dn1_w = 32'(dn1);
        p0_w  = 32'(p0);
        p1_w  = 32'(p1);
    end

    // rule conditions
    always_comb begin
        fire_qr   = (up0 > qr) || (up1 > qr);
        fire_sr   = ((up0 < qr) && (up0 > sr)) || ((up1 < qr) && (up1 > sr));
        fire_qf   = (dn0 > qf) || (dn1 > qf);
        fire_keep = (p0_w > 32'(KEEP_FLOOR)) && (p1_w > 32'(KEEP_FLOOR)) &&
                    (((dn0 > 0) && (dn0 < kb)) || ((dn1 > 0) && (dn1 < kb)));
        fire_rel  = (p0_w < 32'(RELEASE_CEIL)) && (p1_w < 32'(RELEASE_CEIL)) &&
                    (dn0_w < RELEASE_BAND) && (dn0_w > -RELEASE_BAND) &&
                    (dn1_w < RELEASE_BAND) && (dn1_w > -RELEASE_BAND);
    end

    // last rule that fires wins, else the held values stay
    always_comb begin
        priority if (fire_rel) begin
            axle_next = '{mode: MODE_RELEASE, drive: '0};
        end else if (fire_keep) begin
            axle_next = '{mode: MODE_KEEP, drive: cfg.keep_drive};
        end else if (fire_qf) begin
            axle_next = '{mode: MODE_QUICK_FALL, drive: '0};
        end else if (fire_sr) begin
            axle_next = '{mode: MODE_SLOW_RISE, drive: cfg.slow_rise_drive};
        end else if (fire_qr) begin
            axle_next = '{mode: MODE_QUICK_RISE, drive: cfg.quick_rise_drive};
        end else begin
            axle_next = held_reg;
        end
    end

    // held state follows each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '{mode: MODE_RELEASE, drive: '0};
        end else if (advance) begin
            held_reg <= axle_next;
        end
    end

endmodule

// ----- hw/rtl/bpms_merge.sv -----
// merge stage: pump drive from both lanes and the overpressure check
module bpms_merge (
    input  bpms_pkg::axle_t     front,
    input  bpms_pkg::axle_t     rear,
    input  bpms_pkg::pressure_t lf_p,
    input  bpms_pkg::pressure_t rf_p,
    input  bpms_pkg::pressure_t lr_p,
    input  bpms_pkg::pressure_t rr_p,
    input  bpms_pkg::pressure_t limit,
    output bpms_pkg::result_t   result
);
    import bpms_pkg::*;

    // larger axle drive goes to the pump
    always_comb begin
        result.front_mode  = front.mode;
        result.rear_mode   = rear.mode;
        result.front_drive = front.drive;
        result.rear_drive  = rear.drive;
        result.pump_drive  = (front.drive > rear.drive) ? front.drive : rear.drive;
        result.overpressure_release = (lf_p > limit) || (rf_p > limit) ||
                                      (lr_p > limit) || (rr_p > limit);
    end

endmodule

// ----- hw/rtl/brake_pressure_mode_selector.sv -----
// top level: config registers, two axle lanes, merge stage and output register
//
// Takes one transaction per clock and returns one result per transaction, registered in the cycle
// after it is accepted. Both axle lanes and the merge stage settle within the accepting cycle,
// and the held mode and drive update in the same edge, so the next transaction may
// follow at once; throughput is one per cycle, limited only by m_tready through the
// single output register. Configuration writes are always taken (cfg_ready is high)
// and should be made while no transaction is in flight.
module brake_pressure_mode_selector (
    input  logic                                aclk,
    input  logic                                aresetn,
    // lf_p, rf_p, lr_p, rr_p, lf_t, rf_t, lr_t, rr_t pressures, lowest bits first
    input  logic [bpms_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // front_mode, rear_mode, front_drive, rear_drive, pump_drive,
    // overpressure_release, zero pad, lowest bits first
    output logic [bpms_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bpms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bpms_pkg::*;

    cfg_t      cfg_reg;
    result_t   result_reg;
    logic      m_tvalid_reg;
    pressure_t press [IN_FIELDS];
    axle_t     front_next, rear_next;
    result_t   result_next;
    logic      accept;

    // unpack the input transaction
    always_comb begin
        for (int i = 0; i < IN_FIELDS; i++) begin
            press[i] = s_tdata[i*PRESSURE_BITS +: PRESSURE_BITS];
        end
    end

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quick_rise_drive   <= DRIVE_BITS'(60);
            cfg_reg.slow_rise_drive    <= DRIVE_BITS'(20);
            cfg_reg.keep_drive         <= DRIVE_BITS'(8);
            cfg_reg.quick_rise_gap     <= PRESSURE_BITS'(500);
            cfg_reg.slow_rise_gap      <= PRESSURE_BITS'(100);
            cfg_reg.quick_fall_gap     <= PRESSURE_BITS'(300);
            cfg_reg.keep_band          <= PRESSURE_BITS'(200);
            cfg_reg.overpressure_limit <= PRESSURE_BITS'(3800);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_QUICK_RISE_DRIVE:   cfg_reg.quick_rise_drive   <= cfg_data[DRIVE_BITS-1:0];
                REG_SLOW_RISE_DRIVE:    cfg_reg.slow_rise_drive    <= cfg_data[DRIVE_BITS-1:0];
                REG_KEEP_DRIVE:         cfg_reg.keep_drive         <= cfg_data[DRIVE_BITS-1:0];
                REG_QUICK_RISE_GAP:     cfg_reg.quick_rise_gap     <= cfg_data[PRESSURE_BITS-1:0];
                REG_SLOW_RISE_GAP:      cfg_reg.slow_rise_gap      <= cfg_data[PRESSURE_BITS-1:0];
                REG_QUICK_FALL_GAP:     cfg_reg.quick_fall_gap     <= cfg_data[PRESSURE_BITS-1:0];
                REG_KEEP_BAND:          cfg_reg.keep_band          <= cfg_data[PRESSURE_BITS-1:0];
                REG_OVERPRESSURE_LIMIT: cfg_reg.overpressure_limit <= cfg_data[PRESSURE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // front axle lane
    bpms_axle u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .cfg       (cfg_reg),
        .p0        (press[0]),
        .t0        (press[4]),
        .p1        (press[1]),
        .t1        (press[5]),
        .axle_next (front_next)
    );

    // rear axle lane
    bpms_axle u_rear (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .cfg       (cfg_reg),
        .p0        (press[2]),
        .t0        (press[6]),
        .p1        (press[3]),
        .t1        (press[7]),
        .axle_next (rear_next)
    );

    // combine lane results
    bpms_merge u_merge (
        .front  (front_next),
        .rear   (rear_next),
        .lf_p   (press[0]),
        .rf_p   (press[1]),
        .lr_p   (press[2]),
        .rr_p   (press[3]),
        .limit  (cfg_reg.overpressure_limit),
        .result (result_next)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_BITS'(result_reg);

    // pump drive is the larger axle drive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (result_reg.pump_drive >= result_reg.front_drive) &&
                     (result_reg.pump_drive >= result_reg.rear_drive) &&
                     ((result_reg.pump_drive == result_reg.front_drive) ||
                      (result_reg.pump_drive == result_reg.rear_drive)))
        else $error("pump drive is not the larger axle drive");

    // release and quick fall always carry zero drive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((result_reg.front_mode == MODE_RELEASE) ||
                     (result_reg.front_mode == MODE_QUICK_FALL))
        |-> (result_reg.front_drive == '0))
        else $error("front drive not zero in release or quick fall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((result_reg.rear_mode == MODE_RELEASE) ||
                     (result_reg.rear_mode == MODE_QUICK_FALL))
        |-> (result_reg.rear_drive == '0))
        else $error("rear drive not zero in release or quick fall");

    // every accepted transaction shows up as a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted transaction produced no result");

endmodule

// ----- sim/bpms_scoreboard_pkg.sv -----
// scoreboard class of the brake pressure mode selector testbench: mode prediction and result checks
package bpms_scoreboard_pkg;
    import bpms_pkg::*;

    class brake_mode_scoreboard;
        // copy of the configuration registers
        drive_t    quick_rise_drive;
        drive_t    slow_rise_drive;
        drive_t    keep_drive;
        pressure_t quick_rise_gap;
        pressure_t slow_rise_gap;
        pressure_t quick_fall_gap;
        pressure_t keep_band;
        pressure_t overpressure_limit;

        // held axle decisions
        mode_t  front_mode_held;
        mode_t  rear_mode_held;
        drive_t front_drive_held;
        drive_t rear_drive_held;

        result_t expected_results[$];
        int      errors;

        function new();
            quick_rise_drive   = 8'd60;
            slow_rise_drive    = 8'd20;
            keep_drive         = 8'd8;
            quick_rise_gap     = 12'd500;
            slow_rise_gap      = 12'd100;
            quick_fall_gap     = 12'd300;
            keep_band          = 12'd200;
            overpressure_limit = 12'd3800;
            front_mode_held    = MODE_RELEASE;
            rear_mode_held     = MODE_RELEASE;
            front_drive_held   = '0;
            rear_drive_held    = '0;
            errors             = 0;
        endfunction

        // register write accepted by the block
        function void note_config(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] value);
            case (index)
                REG_QUICK_RISE_DRIVE:   quick_rise_drive   = value[DRIVE_BITS-1:0];
                REG_SLOW_RISE_DRIVE:    slow_rise_drive    = value[DRIVE_BITS-1:0];
                REG_KEEP_DRIVE:         keep_drive         = value[DRIVE_BITS-1:0];
                REG_QUICK_RISE_GAP:     quick_rise_gap     = value[PRESSURE_BITS-1:0];
                REG_SLOW_RISE_GAP:      slow_rise_gap      = value[PRESSURE_BITS-1:0];
                REG_QUICK_FALL_GAP:     quick_fall_gap     = value[PRESSURE_BITS-1:0];
                REG_KEEP_BAND:          keep_band          = value[PRESSURE_BITS-1:0];
                REG_OVERPRESSURE_LIMIT: overpressure_limit = value[PRESSURE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // ordered rules of one axle, the last rule that fires wins
        function void decide_axle(int p0, int t0, int p1, int t1,
                                  inout mode_t mode, inout drive_t drive);
            int up0, up1, dn0, dn1, ad0, ad1;
            int qr, sr, qf, kb;
            up0 = t0 - p0;
            up1 = t1 - p1;
            dn0 = p0 - t0;
            dn1 = p1 - t1;
            ad0 = (dn0 < 0) ? -dn0 : dn0;
            ad1 = (dn1 < 0) ? -dn1 : dn1;
            qr  = quick_rise_gap;
            sr  = slow_rise_gap;
            qf  = quick_fall_gap;
            kb  = keep_band;
            if (up0 > qr || up1 > qr) begin
                mode  = MODE_QUICK_RISE;
                drive = quick_rise_drive;
            end
            if ((up0 < qr && up0 > sr) || (up1 < qr && up1 > sr)) begin
                mode  = MODE_SLOW_RISE;
                drive = slow_rise_drive;
            end
            if (dn0 > qf || dn1 > qf) begin
                mode  = MODE_QUICK_FALL;
                drive = '0;
            end
            if (p0 > KEEP_FLOOR && p1 > KEEP_FLOOR &&
                ((dn0 > 0 && dn0 < kb) || (dn1 > 0 && dn1 < kb))) begin
                mode  = MODE_KEEP;
                drive = keep_drive;
            end
            if (p0 < RELEASE_CEIL && p1 < RELEASE_CEIL &&
                ad0 < RELEASE_BAND && ad1 < RELEASE_BAND) begin
                mode  = MODE_RELEASE;
                drive = '0;
            end
        endfunction

        // tick transaction accepted: update held state and queue the expected result
        function void note_tick(logic [IN_DATA_BITS-1:0] data);
            int      f [IN_FIELDS];
            int      lim;
            result_t r;
            for (int i = 0; i < IN_FIELDS; i++)
                f[i] = data[i*PRESSURE_BITS +: PRESSURE_BITS];
            decide_axle(f[0], f[4], f[1], f[5], front_mode_held, front_drive_held);
            decide_axle(f[2], f[6], f[3], f[7], rear_mode_held, rear_drive_held);
            lim = overpressure_limit;
            r.front_mode  = front_mode_held;
            r.rear_mode   = rear_mode_held;
            r.front_drive = front_drive_held;
            r.rear_drive  = rear_drive_held;
            r.pump_drive  = (front_drive_held > rear_drive_held) ? front_drive_held
                                                                 : rear_drive_held;
            r.overpressure_release = (f[0] > lim || f[1] > lim || f[2] > lim || f[3] > lim);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // result transaction accepted: compare with the oldest expectation
        function void check_result(logic [OUT_DATA_BITS-1:0] data);
            result_t got, want;
            got = data[OUT_USED_BITS-1:0];
            if (expected_results.size() == 0) begin
                $error("result with no tick waiting: %h", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("front_mode", want.front_mode, got.front_mode);
            compare_field("rear_mode", want.rear_mode, got.rear_mode);
            compare_field("front_drive", want.front_drive, got.front_drive);
            compare_field("rear_drive", want.rear_drive, got.rear_drive);
            compare_field("pump_drive", want.pump_drive, got.pump_drive);
            compare_field("overpressure_release", want.overpressure_release,
                          got.overpressure_release);
            compare_field("pad", 0, data[OUT_DATA_BITS-1:OUT_USED_BITS]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

// ----- sim/tb_brake_pressure_mode_selector.sv -----
// testbench top of the brake pressure mode selector: stimulus, handshakes and final verdict
module tb_brake_pressure_mode_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import bpms_pkg::*;
    import bpms_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                      aclk;
    logic                      aresetn;
    logic [IN_DATA_BITS-1:0]   s_tdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    brake_mode_scoreboard sb;
    bit                   steady;
    int                   cycle_count;

    brake_pressure_mode_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** brake_pressure_mode_selector: FAILED **");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (steady)
            m_tready = 1'b1;
        else
            m_tready = ($urandom_range(0, 99) >= 21);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic pressure_t clamp_pressure(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return pressure_t'(v);
    endfunction

    // one wheel: pressure and target steered toward a rule or a boundary
    function automatic void random_wheel(int sel, output pressure_t p, output pressure_t t);
        int pv, delta, lim;
        case ($urandom_range(0, 3))
            0: pv = $urandom_range(0, 499);
            1: pv = $urandom_range(495, 605);
            2: pv = $urandom_range(601, 3799);
            default: pv = $urandom_range(3700, 4095);
        endcase
        lim = sb.overpressure_limit;
        case (sel)
            0: begin
                pv    = $urandom_range(0, 4095);
                delta = int'($urandom_range(0, 4095)) - pv;
            end
            1, 2: begin
                pv    = $urandom_range(0, 499);
                delta = int'($urandom_range(0, 398)) - 199;
            end
            3: delta = int'(sb.quick_rise_gap) + int'($urandom_range(0, 2)) - 1;
            4: delta = int'(sb.slow_rise_gap) + int'($urandom_range(0, 2)) - 1;
            5: delta = -(int'(sb.quick_fall_gap) + int'($urandom_range(0, 2)) - 1);
            6: delta = -int'($urandom_range(0, sb.keep_band));
            7: delta = int'($urandom_range(0, 1600)) - 800;
            8: begin
                pv    = $urandom_range(0, 1) ? 4095 : 0;
                delta = $urandom_range(0, 1) ? (4095 - 2 * pv) : 0;
            end
            default: begin
                pv    = lim + int'($urandom_range(0, 4)) - 2;
                delta = int'($urandom_range(0, 400)) - 200;
            end
        endcase
        p = clamp_pressure(pv);
        t = clamp_pressure(pv + delta);
    endfunction

    // random tick, wheels of an axle often aimed at the same rule
    function automatic logic [IN_DATA_BITS-1:0] random_tick();
        logic [IN_DATA_BITS-1:0] data;
        pressure_t               p, t;
        int                      sel;
        data = '0;
        for (int w = 0; w < WHEELS; w++) begin
            if (w % 2 == 0 || $urandom_range(0, 99) >= 60)
                sel = $urandom_range(0, 9);
            random_wheel(sel, p, t);
            data[w*PRESSURE_BITS +: PRESSURE_BITS]           = p;
            data[(w + WHEELS)*PRESSURE_BITS +: PRESSURE_BITS] = t;
        end
        return data;
    endfunction

    // send one tick transaction, starting and ending at a falling edge
    task automatic send_tick(logic [IN_DATA_BITS-1:0] data);
        while (!steady && $urandom_range(0, 99) < 21) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = data;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(data);
        @(negedge aclk);
    endtask

    task automatic wheel_tick(int lfp, int rfp, int lrp, int rrp,
                              int lft, int rft, int lrt, int rrt);
        send_tick({pressure_t'(rrt), pressure_t'(lrt), pressure_t'(rft), pressure_t'(lft),
                   pressure_t'(rrp), pressure_t'(lrp), pressure_t'(rfp), pressure_t'(lfp)});
    endtask

    // wait until every expected result has arrived
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, int value);
        cfg_index = index;
        cfg_data  = CFG_DATA_BITS'(value);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(index, cfg_data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_random_config();
        write_reg(REG_QUICK_RISE_DRIVE, $urandom_range(0, 4095));
        write_reg(REG_SLOW_RISE_DRIVE, $urandom_range(0, 4095));
        write_reg(REG_KEEP_DRIVE, $urandom_range(0, 4095));
        write_reg(REG_QUICK_RISE_GAP, $urandom_range(0, 4095));
        write_reg(REG_SLOW_RISE_GAP, $urandom_range(0, 4095));
        write_reg(REG_QUICK_FALL_GAP, $urandom_range(0, 4095));
        write_reg(REG_KEEP_BAND, $urandom_range(0, 4095));
        write_reg(REG_OVERPRESSURE_LIMIT, $urandom_range(0, 4095));
    endtask

    task automatic random_ticks(int count);
        repeat (count) send_tick(random_tick());
    endtask

    initial begin
        sb          = new();
        cycle_count = 0;
        steady      = 1'b0;
        aresetn     = 1'b0;
        s_tdata     = '0;
        s_tvalid    = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_QUICK_RISE_DRIVE;
        cfg_data    = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed ticks with reset configuration
        wheel_tick(0, 0, 0, 0, 0, 0, 0, 0);
        // front quick rise, rear holds
        wheel_tick(0, 0, 1000, 1000, 4095, 0, 1000, 1000);
        // rear quick rise sets the rear drive
        wheel_tick(1000, 1000, 700, 700, 1000, 1000, 1300, 700);
        // gap equal to quick rise gap fires neither rise rule
        wheel_tick(1000, 1000, 1000, 1000, 1500, 1000, 1500, 1000);
        // just over and just under the quick rise gap
        wheel_tick(1000, 1000, 1000, 1000, 1501, 1000, 1499, 1000);
        // slow rise gap edges
        wheel_tick(800, 800, 800, 800, 901, 800, 900, 800);
        // quick fall on front, fall gap edge on rear
        wheel_tick(1000, 1000, 1000, 1000, 699, 1000, 700, 1000);
        // keep alone on front, quick fall overridden by keep on rear
        wheel_tick(1000, 1000, 1000, 1000, 900, 1000, 500, 950);
        // keep floor and keep band edges
        wheel_tick(600, 1000, 700, 700, 550, 1000, 500, 700);
        // release overrides slow rise, release band edge on rear
        wheel_tick(100, 200, 499, 499, 250, 200, 699, 699);
        // release ceiling edge
        wheel_tick(500, 0, 500, 0, 500, 0, 500, 0);
        // overpressure limit edges, one wheel at a time
        wheel_tick(3800, 3800, 3800, 3800, 3800, 3800, 3800, 3800);
        wheel_tick(3801, 3800, 3800, 3800, 3801, 3800, 3800, 3800);
        wheel_tick(3800, 3801, 3800, 3800, 3800, 3801, 3800, 3800);
        wheel_tick(3800, 3800, 3801, 3800, 3800, 3800, 3801, 3800);
        wheel_tick(3800, 3800, 3800, 3801, 3800, 3800, 3800, 3801);
        // full scale fall and rise
        wheel_tick(4095, 4095, 4095, 4095, 0, 0, 0, 0);
        wheel_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
        // rise and fall on one axle, slow rise and keep on the other
        wheel_tick(1000, 1000, 1000, 1000, 1600, 600, 1200, 900);
        // all at full scale: nothing fires, state holds
        wheel_tick(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        random_ticks(60);
        drain();

        // random configuration, with a pause until the block is empty
        write_random_config();
        random_ticks(120);
        drain();
        random_ticks(120);
        drain();

        // all registers at zero
        write_reg(REG_QUICK_RISE_DRIVE, 0);
        write_reg(REG_SLOW_RISE_DRIVE, 0);
        write_reg(REG_KEEP_DRIVE, 0);
        write_reg(REG_QUICK_RISE_GAP, 0);
        write_reg(REG_SLOW_RISE_GAP, 0);
        write_reg(REG_QUICK_FALL_GAP, 0);
        write_reg(REG_KEEP_BAND, 0);
        write_reg(REG_OVERPRESSURE_LIMIT, 0);
        random_ticks(130);
        drain();

        // all registers at full scale, drive registers keep their low byte
        write_reg(REG_QUICK_RISE_DRIVE, 4095);
        write_reg(REG_SLOW_RISE_DRIVE, 4095);
        write_reg(REG_KEEP_DRIVE, 4095);
        write_reg(REG_QUICK_RISE_GAP, 4095);
        write_reg(REG_SLOW_RISE_GAP, 4095);
        write_reg(REG_QUICK_FALL_GAP, 4095);
        write_reg(REG_KEEP_BAND, 4095);
        write_reg(REG_OVERPRESSURE_LIMIT, 4095);
        random_ticks(130);
        drain();

        // slow rise gap above quick rise gap
        write_random_config();
        write_reg(REG_QUICK_RISE_GAP, 150);
        write_reg(REG_SLOW_RISE_GAP, 600);
        random_ticks(150);
        drain();

        // reset values again, with a stretch where neither side idles
        write_reg(REG_QUICK_RISE_DRIVE, 60);
        write_reg(REG_SLOW_RISE_DRIVE, 20);
        write_reg(REG_KEEP_DRIVE, 8);
        write_reg(REG_QUICK_RISE_GAP, 500);
        write_reg(REG_SLOW_RISE_GAP, 100);
        write_reg(REG_QUICK_FALL_GAP, 300);
        write_reg(REG_KEEP_BAND, 200);
        write_reg(REG_OVERPRESSURE_LIMIT, 3800);
        random_ticks(60);
        steady = 1'b1;
        random_ticks(120);
        steady = 1'b0;
        random_ticks(60);

        drain();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0)
            $display("** brake_pressure_mode_selector: PASSED **");
        else
            $display("** brake_pressure_mode_selector: FAILED **");
        $finish;
    end

endmodule
